FILE: src/ft12_pkg.sv
// Shared types, codes and constants of the FT1.2 frame receiver.
package ft12_pkg;

   localparam logic [7:0]  FIXED_START = 8'h10;
   localparam logic [7:0]  VAR_START   = 8'h68;
   localparam logic [7:0]  STOP_BYTE   = 8'h16;
   localparam logic [15:0] MIN_GAP     = 16'd2000;

   localparam logic [1:0] PH_HUNT  = 2'd0;
   localparam logic [1:0] PH_FIXED = 2'd1;
   localparam logic [1:0] PH_VAR   = 2'd2;

   localparam logic [2:0] ST_BUSY = 3'd0;
   localparam logic [2:0] ST_GOOD = 3'd1;
   localparam logic [2:0] ST_CSUM = 3'd2;
   localparam logic [2:0] ST_STOP = 3'd3;
   localparam logic [2:0] ST_HEAD = 3'd4;
   localparam logic [2:0] ST_ADDR = 3'd5;
   localparam logic [2:0] ST_TIME = 3'd6;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP     = 2'd1;

   localparam logic [7:0]  STATION_RESET = 8'd1;
   localparam logic [15:0] GAP_RESET     = 16'd2000;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [8:0] byte_index;
      logic       frame_kind;
      logic       last;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [8:0]  position;
      logic [7:0]  user_length;
      logic [7:0]  running_sum;
      logic [15:0] idle_ticks;
   } state_type;

   localparam state_type HUNT_STATE = '{
      phase:       PH_HUNT,
      position:    9'd0,
      user_length: 8'd0,
      running_sum: 8'd0,
      idle_ticks:  16'd0
   };

endpackage

FILE: src/ft12_if.sv
// Handshake channels of the FT1.2 frame receiver: request, response, register write.
interface ft12_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;
   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface ft12_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [8:0] byte_index;
   logic       frame_kind;
   logic       last;
   logic [2:0] status;
   modport source (output valid, output out_byte, output byte_index, output frame_kind,
                   output last, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_index, input frame_kind,
                   input last, input status, output ready);
endinterface

interface ft12_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ft12_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ft12_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ft12_frame_receiver_core.sv
// Top level of the FT1.2 frame receiver: input register, frame state, response register.
// A request passes through the input register, then the frame state update into the
//   response register.
// Throughput: one request per cycle while the response register is free or draining.
// Requests that yield no response (dropped bytes, ticks) still pass through the input register.
// Reset (synchronous, active high): hunting for a start byte, registers to their
//   default values (station address 1, gap limit 2000), both pipeline stages empty.
module ft12_frame_receiver_core (
   input  logic              clock,
   input  logic              reset,
   ft12_req_if.sink          req_bus,
   ft12_rsp_if.source        rsp_bus,
   ft12_csr_if.sink          csr_bus
);

   logic                in_valid_ff, in_valid_in;
   ft12_pkg::req_type   in_req_ff, in_req_in;
   ft12_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   ft12_pkg::rsp_type   out_rsp_ff;
   logic [7:0]          station_ff, station_in;
   logic [15:0]         gap_ff, gap_in;

   ft12_pkg::state_type nxt_state;
   logic                res_valid;
   ft12_pkg::rsp_type   res;
   logic                advance;
   logic                req_take;

   ft12_decode u_decode (
      .cur_state       (state_ff),
      .req             (in_req_ff),
      .station_address (station_ff),
      .gap_limit       (gap_ff),
      .nxt_state       (nxt_state),
      .res_valid       (res_valid),
      .res             (res)
   );

   // input stage moves on when the response register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in       = 1'b1;
         in_req_in.func    = req_bus.func;
         in_req_in.rx_byte = req_bus.rx_byte;
      end
   end

   assign state_in = advance ? nxt_state : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_comb begin
      station_in = station_ff;
      gap_in     = gap_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == ft12_pkg::CSR_STATION) begin
            station_in = csr_bus.data[7:0];
         end else if (csr_bus.index == ft12_pkg::CSR_GAP) begin
            gap_in = csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ft12_pkg::HUNT_STATE;
         out_valid_ff <= 1'b0;
         station_ff   <= ft12_pkg::STATION_RESET;
         gap_ff       <= ft12_pkg::GAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         station_ff   <= station_in;
         gap_ff       <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      if (advance && res_valid) begin
         out_rsp_ff <= res;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_byte   = out_rsp_ff.out_byte;
   assign rsp_bus.byte_index = out_rsp_ff.byte_index;
   assign rsp_bus.frame_kind = out_rsp_ff.frame_kind;
   assign rsp_bus.last       = out_rsp_ff.last;
   assign rsp_bus.status     = out_rsp_ff.status;

`ifndef SYNTHESIS
   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && res.last) |=> (state_ff.phase == ft12_pkg::PH_HUNT))
      else $error("frame end did not return to hunting");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != ft12_pkg::ST_BUSY) |-> rsp_bus.last)
      else $error("final status on a response without last");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == ft12_pkg::PH_HUNT) |->
         (state_ff.position == 9'd0 && state_ff.idle_ticks == 16'd0))
      else $error("hunting with stale frame state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !advance)
      else $error("pending response overwritten");
`endif

endmodule

FILE: src/ft12_decode.sv
// Per-request frame state update and response generation.
module ft12_decode (
   input  ft12_pkg::state_type cur_state,
   input  ft12_pkg::req_type   req,
   input  logic [7:0]          station_address,
   input  logic [15:0]         gap_limit,
   output ft12_pkg::state_type nxt_state,
   output logic                res_valid,
   output ft12_pkg::rsp_type   res
);

   logic [15:0] limit;
   logic [15:0] ticks_inc;
   logic [8:0]  pos;
   logic [8:0]  user_end;
   logic [7:0]  b;
   logic [2:0]  end_status;

   assign limit     = (gap_limit < ft12_pkg::MIN_GAP) ? ft12_pkg::MIN_GAP : gap_limit;
   assign ticks_inc = (cur_state.idle_ticks == 16'hFFFF) ? cur_state.idle_ticks
                                                         : cur_state.idle_ticks + 16'd1;
   assign pos       = cur_state.position;
   assign b         = req.rx_byte;
   // last user byte sits at index 3 + L
   assign user_end  = {1'b0, cur_state.user_length} + 9'd3;
   // stop byte error wins over checksum error
   assign end_status = (b != ft12_pkg::STOP_BYTE) ? ft12_pkg::ST_STOP :
                       (cur_state.running_sum != 8'd0) ? ft12_pkg::ST_CSUM :
                       ft12_pkg::ST_GOOD;

   always_comb begin
      nxt_state           = cur_state;
      res_valid           = 1'b0;
      res.out_byte        = b;
      res.byte_index      = pos;
      res.frame_kind      = (cur_state.phase == ft12_pkg::PH_VAR);
      res.last            = 1'b0;
      res.status          = ft12_pkg::ST_BUSY;
      if (req.func) begin
         if (cur_state.phase != ft12_pkg::PH_HUNT) begin
            nxt_state.idle_ticks = ticks_inc;
            if (ticks_inc >= limit) begin
               res_valid    = 1'b1;
               res.out_byte = 8'd0;
               res.last     = 1'b1;
               res.status   = ft12_pkg::ST_TIME;
               nxt_state    = ft12_pkg::HUNT_STATE;
            end
         end
      end else begin
         nxt_state.idle_ticks = 16'd0;
         unique case (cur_state.phase)
            ft12_pkg::PH_HUNT: begin
               if (b == ft12_pkg::FIXED_START || b == ft12_pkg::VAR_START) begin
                  nxt_state.phase       = (b == ft12_pkg::FIXED_START) ? ft12_pkg::PH_FIXED
                                                                       : ft12_pkg::PH_VAR;
                  nxt_state.position    = 9'd1;
                  nxt_state.running_sum = 8'd0;
                  nxt_state.user_length = 8'd0;
                  res_valid             = 1'b1;
                  res.byte_index        = 9'd0;
                  res.frame_kind        = (b == ft12_pkg::VAR_START);
               end
            end
            ft12_pkg::PH_FIXED: begin
               res_valid = 1'b1;
               priority if (pos <= 9'd2) begin
                  nxt_state.running_sum = cur_state.running_sum + b;
                  nxt_state.position    = pos + 9'd1;
               end else if (pos == 9'd3) begin
                  nxt_state.running_sum = cur_state.running_sum ^ b;
                  nxt_state.position    = pos + 9'd1;
               end else begin
                  res.last   = 1'b1;
                  res.status = end_status;
                  nxt_state  = ft12_pkg::HUNT_STATE;
               end
            end
            ft12_pkg::PH_VAR: begin
               res_valid          = 1'b1;
               nxt_state.position = pos + 9'd1;
               priority if (pos == 9'd1) begin
                  if (b < 8'd2) begin
                     res.last   = 1'b1;
                     res.status = ft12_pkg::ST_HEAD;
                     nxt_state  = ft12_pkg::HUNT_STATE;
                  end else begin
                     nxt_state.user_length = b;
                  end
               end else if (pos == 9'd2) begin
                  if (b != cur_state.user_length) begin
                     res.last   = 1'b1;
                     res.status = ft12_pkg::ST_HEAD;
                     nxt_state  = ft12_pkg::HUNT_STATE;
                  end
               end else if (pos == 9'd3) begin
                  if (b != ft12_pkg::VAR_START) begin
                     res.last   = 1'b1;
                     res.status = ft12_pkg::ST_HEAD;
                     nxt_state  = ft12_pkg::HUNT_STATE;
                  end
               end else if (pos <= user_end) begin
                  if (pos == 9'd5 && b != station_address) begin
                     res.last   = 1'b1;
                     res.status = ft12_pkg::ST_ADDR;
                     nxt_state  = ft12_pkg::HUNT_STATE;
                  end else begin
                     nxt_state.running_sum = cur_state.running_sum + b;
                  end
               end else if (pos == user_end + 9'd1) begin
                  nxt_state.running_sum = cur_state.running_sum ^ b;
               end else begin
                  res.last   = 1'b1;
                  res.status = end_status;
                  nxt_state  = ft12_pkg::HUNT_STATE;
               end
            end
            default: begin
               nxt_state = ft12_pkg::HUNT_STATE;
            end
         endcase
      end
   end

endmodule
